// ----- hdl/rms_pkg.sv -----
// Shared types, constants and arithmetic helpers for the stereo resampling mixer.
package rms_pkg;

  localparam int FRAMES_DEF = 4096;

  localparam int IDX_W     = 12;
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int FRAC_W    = 32;
  localparam int MIX_W     = 32;
  localparam int FRAME_W   = 2 * SAMPLE_W;
  localparam int PROD_W    = SAMPLE_W + GAIN_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int REQ_W     = 2;
  localparam int GAIN_FRAC_BITS = 14;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 112;

  localparam logic [IDX_W-1:0]  STEP_INT_RST = 12'd1;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 16'sd16384;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_SET  = 2'd1,
    REQ_MIX  = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_INT   = 2'd0,
    CFG_STEP_FRAC  = 2'd1,
    CFG_LEFT_GAIN  = 2'd2,
    CFG_RIGHT_GAIN = 2'd3
  } cfg_idx_t;

  // Round a Q18.14 product to integer units (ties toward plus infinity),
  // add it to the mix value and clamp to the 32-bit signed range.
  function automatic logic [MIX_W-1:0] mix_sat(input logic signed [MIX_W-1:0] mix,
                                               input logic signed [PROD_W-1:0] prod);
    logic signed [MIX_W+1:0] prod_ext;
    logic signed [MIX_W+1:0] scaled;
    logic signed [MIX_W+1:0] sum;
    prod_ext = (MIX_W+2)'(prod);
    scaled   = (prod_ext + (MIX_W+2)'(1 << (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
    sum      = (MIX_W+2)'(mix) + scaled;
    if (sum > (MIX_W+2)'(34'sh0_7FFF_FFFF)) begin
      mix_sat = 32'h7FFF_FFFF;
    end else if (sum < -(MIX_W+2)'(34'sh0_8000_0000)) begin
      mix_sat = 32'h8000_0000;
    end else begin
      mix_sat = sum[MIX_W-1:0];
    end
  endfunction

endpackage

// ----- hdl/rms_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module rms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/resample_mix_stereo.sv -----
// Stereo nearest-neighbor resampling mixer with a 12.32 read position (default FRAMES).
// A mix transfer yields its result on m_tvalid from the output register of the pipeline.
// Throughput: one item per cycle; the three-stage pipeline (frame read, multiply,
// round and saturate) stalls only while the output register holds an untaken result.
// Reset: synchronous; clears position, pipeline valids and configuration registers to reset values.
// The sample store is not cleared; FRAMES must be a power of two, which the block does not check.
module resample_mix_stereo #(
  parameter int FRAMES = rms_pkg::FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // frame_index, sample_even, sample_odd, position_frac_in, mix_left_in,
  // mix_right_in, zero fill
  input  logic [rms_pkg::IN_DATA_W-1:0]   s_tdata,
  // req_type
  input  logic [rms_pkg::REQ_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // mix_left_out, mix_right_out, position_int_out, position_frac_out, zero fill
  output logic [rms_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [rms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rms_pkg::*;

  localparam int ADDR_W = $clog2(FRAMES);

  // Input fields
  logic [IDX_W-1:0]           frame_index;
  logic [SAMPLE_W-1:0]        sample_even;
  logic [SAMPLE_W-1:0]        sample_odd;
  logic [FRAC_W-1:0]          position_frac_in;
  logic signed [MIX_W-1:0]    mix_left_in;
  logic signed [MIX_W-1:0]    mix_right_in;

  assign frame_index      = s_tdata[11:0];
  assign sample_even      = s_tdata[27:12];
  assign sample_odd       = s_tdata[43:28];
  assign position_frac_in = s_tdata[75:44];
  assign mix_left_in      = s_tdata[107:76];
  assign mix_right_in     = s_tdata[139:108];

  // Configuration
  logic [IDX_W-1:0]         step_int;
  logic [FRAC_W-1:0]        step_frac;
  logic signed [GAIN_W-1:0] gain_l;
  logic signed [GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_int  <= STEP_INT_RST;
      step_frac <= '0;
      gain_l    <= GAIN_RST;
      gain_r    <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STEP_INT:   step_int  <= cfg_data[IDX_W-1:0];
        CFG_STEP_FRAC:  step_frac <= cfg_data[FRAC_W-1:0];
        CFG_LEFT_GAIN:  gain_l    <= cfg_data[GAIN_W-1:0];
        CFG_RIGHT_GAIN: gain_r    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic v1, v2, v3;
  logic ready1, ready2, ready3;
  logic accept;
  logic is_load, is_set, is_mix;

  assign ready3   = !v3 || m_tready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;
  assign accept   = s_tvalid && ready1;

  always_comb begin
    is_load = 1'b0;
    is_set  = 1'b0;
    is_mix  = 1'b0;
    case (req_t'(s_tuser))
      REQ_LOAD: is_load = 1'b1;
      REQ_SET:  is_set  = 1'b1;
      REQ_MIX:  is_mix  = 1'b1;
      default: ;
    endcase
  end

  // Read position accumulator
  logic [ADDR_W-1:0]        position_int;
  logic [FRAC_W-1:0]        position_frac;
  logic [ADDR_W-1:0]        position_int_next;
  logic [FRAC_W-1:0]        position_frac_next;
  logic [FRAC_W:0]          fsum;
  logic [ADDR_W+IDX_W:0]    isum;
  logic [ADDR_W+IDX_W-1:0]  index_ext;
  logic [ADDR_W+IDX_W-1:0]  pos_ext;

  assign index_ext = {{ADDR_W{1'b0}}, frame_index};
  assign fsum = {1'b0, position_frac} + {1'b0, step_frac};
  assign isum = {{(IDX_W+1){1'b0}}, position_int} + {{(ADDR_W+1){1'b0}}, step_int}
              + {{(ADDR_W+IDX_W){1'b0}}, fsum[FRAC_W]};

  always_comb begin
    position_int_next  = position_int;
    position_frac_next = position_frac;
    if (accept && is_set) begin
      position_int_next  = index_ext[ADDR_W-1:0];
      position_frac_next = position_frac_in;
    end else if (accept && is_mix) begin
      position_int_next  = isum[ADDR_W-1:0];
      position_frac_next = fsum[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_int  <= '0;
      position_frac <= '0;
    end else begin
      position_int  <= position_int_next;
      position_frac <= position_frac_next;
    end
  end

  assign pos_ext = {{IDX_W{1'b0}}, position_int_next};

  // Sample store. A load and a mix are never accepted in the same cycle, so a
  // read always sees every earlier write.
  logic [FRAME_W-1:0] frame_q;

  rms_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (accept && is_load),
    .waddr (index_ext[ADDR_W-1:0]),
    .wdata ({sample_odd, sample_even}),
    .re    (ready1),
    .raddr (position_int),
    .rdata (frame_q)
  );

  // Stage 1: frame being read, side data captured
  logic signed [MIX_W-1:0] mix_l1, mix_r1;
  logic [IDX_W-1:0]        acc_int1;
  logic [FRAC_W-1:0]       acc_frac1;
  // Stage 2: products
  logic signed [PROD_W-1:0] prod_l2, prod_r2;
  logic signed [MIX_W-1:0]  mix_l2, mix_r2;
  logic [IDX_W-1:0]         acc_int2;
  logic [FRAC_W-1:0]        acc_frac2;
  // Stage 3: output register
  logic [MIX_W-1:0]  mix_left_out, mix_right_out;
  logic [IDX_W-1:0]  position_int_out;
  logic [FRAC_W-1:0] position_frac_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= accept && is_mix;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      mix_l1    <= mix_left_in;
      mix_r1    <= mix_right_in;
      acc_int1  <= pos_ext[IDX_W-1:0];
      acc_frac1 <= position_frac_next;
    end
    if (ready2) begin
      // Left gain scales the odd sample, right gain the even sample.
      prod_l2   <= $signed(frame_q[FRAME_W-1:SAMPLE_W]) * gain_l;
      prod_r2   <= $signed(frame_q[SAMPLE_W-1:0]) * gain_r;
      mix_l2    <= mix_l1;
      mix_r2    <= mix_r1;
      acc_int2  <= acc_int1;
      acc_frac2 <= acc_frac1;
    end
    if (ready3) begin
      mix_left_out      <= mix_sat(mix_l2, prod_l2);
      mix_right_out     <= mix_sat(mix_r2, prod_r2);
      position_int_out  <= acc_int2;
      position_frac_out <= acc_frac2;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {4'b0, position_frac_out, position_int_out, mix_right_out, mix_left_out};

endmodule

// ----- hdl/rms_checker.sv -----
// Port-level checks for the stereo resampling mixer, bound to its top level.
module rms_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [rms_pkg::REQ_W-1:0]      s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rms_pkg::OUT_DATA_W-1:0] m_tdata
);
  import rms_pkg::*;

  // Nothing comes out in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The input side only stalls behind a result that waits to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // A result never appears when no mix transfer could have caused it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) && !$past(rst, 3) && !$past(rst, 2) && !$past(rst, 1)
      |-> $past(!s_tready || (s_tvalid && s_tuser == REQ_MIX), 3)
       || $past(!s_tready, 2) || $past(!s_tready, 1))
    else $error("result without a mix transfer");

endmodule

bind resample_mix_stereo rms_checker u_rms_checker (.*);
